FILE: rtl/tap_pkg.sv
// ----------------------------------------------------------------------------
// tap_pkg: shared types and constants of the actuator position tracker
// Commands, motion codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package tap_pkg;

   localparam int unsigned POS_W      = 16;
   localparam int unsigned STALL_W    = 10;
   localparam int unsigned CMD_W      = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam int unsigned SAVE_QUANTUM_DEFAULT = 100;

   // reset values of the configuration registers
   localparam logic [POS_W-1:0]   FULL_TRAVEL_RESET  = 16'd20000;
   localparam logic [STALL_W-1:0] STALL_TIMEOUT_RESET = 10'd50;
   localparam logic [POS_W-1:0]   ENDPOINT_EXTRA_RESET = 16'd5000;

   // reset value of the tracker target and saturation limit of its counters
   localparam logic [POS_W-1:0] TARGET_RESET = 16'hFFFF;
   localparam logic [POS_W-1:0] COUNT_MAX    = 16'hFFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK    = 3'd0,
      CMD_PULSE   = 3'd1,
      CMD_MOVE    = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_RESTORE = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      MOT_STOP = 2'd0,
      MOT_FWD  = 2'd1,
      MOT_BWD  = 2'd2
   } motion_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULL_TRAVEL    = 2'd0,
      CSR_STALL_TIMEOUT  = 2'd1,
      CSR_ENDPOINT_EXTRA = 2'd2
   } csr_index_type;

endpackage

FILE: rtl/tap_if.sv
// ----------------------------------------------------------------------------
// tap_if: channel interfaces of the actuator position tracker
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tap_req_if;
   logic                          valid;
   logic                          ready;
   logic [tap_pkg::CMD_W-1:0]     command;
   logic [tap_pkg::POS_W-1:0]     operand_value;

   modport source (output valid, output command, output operand_value, input ready);
   modport sink   (input valid, input command, input operand_value, output ready);
endinterface

interface tap_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          drive_forward;
   logic                          drive_backward;
   logic [1:0]                    motion;
   logic [tap_pkg::POS_W-1:0]     position_now;
   logic                          move_done;
   logic                          save_strobe;
   logic [tap_pkg::POS_W-1:0]     saved_position;

   modport source (output valid, output drive_forward, output drive_backward,
                   output motion, output position_now, output move_done,
                   output save_strobe, output saved_position, input ready);
   modport sink   (input valid, input drive_forward, input drive_backward,
                   input motion, input position_now, input move_done,
                   input save_strobe, input saved_position, output ready);
endinterface

interface tap_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tap_pkg::CSR_IDX_W-1:0]     index;
   logic [tap_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/timed_actuator_position_tracker.sv
// ----------------------------------------------------------------------------
// timed_actuator_position_tracker: open-loop actuator position estimator
// Throughput: one request per cycle while no response waits; the state
//   updates at the request handshake, then one stage runs the reciprocal
//   multiply for the save value and one stage scales it back to the save
//   quantum.
// Reset: synchronous; registers return to their defaults, state to stopped
//   at position zero, no response pending.
// ----------------------------------------------------------------------------
module timed_actuator_position_tracker #(
   parameter int unsigned SAVE_QUANTUM = tap_pkg::SAVE_QUANTUM_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   tap_req_if.sink        req_ch,
   tap_rsp_if.source      rsp_ch,
   tap_csr_if.sink        csr_ch
);

   localparam int unsigned POS_W   = tap_pkg::POS_W;
   localparam int unsigned QL      = $clog2(SAVE_QUANTUM);
   localparam int unsigned SHIFT   = POS_W + QL;
   localparam int unsigned RECIP_W = POS_W + 1;
   localparam int unsigned PROD_W  = SHIFT + POS_W;
   localparam int unsigned QW      = $clog2(SAVE_QUANTUM + 1);
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + SAVE_QUANTUM - 1) / SAVE_QUANTUM;

   typedef struct packed {
      tap_pkg::motion_type motion;
      logic [POS_W-1:0]    position;
      logic                done;
      logic                save;
   } stage_type;

   // configuration registers
   logic [POS_W-1:0]            full_travel_ff;
   logic [tap_pkg::STALL_W-1:0] stall_timeout_ff;
   logic [POS_W-1:0]            endpoint_extra_ff;

   // tracker state
   tap_pkg::motion_type motion_ff, motion_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic [POS_W-1:0]    target_ff, target_in;
   logic [POS_W-1:0]    budget_ff, budget_in;
   logic [POS_W-1:0]    since_start_ff, since_start_in;
   logic [POS_W-1:0]    since_pulse_ff, since_pulse_in;
   logic                done_in;
   logic                save_in;

   // pipeline
   logic                 advance;
   logic                 req_accept;
   logic                 s1_valid_ff;
   logic                 s2_valid_ff;
   logic                 rsp_valid_ff;
   stage_type            s1_ff;
   stage_type            s2_ff;
   stage_type            s3_ff;
   logic [POS_W-1:0]     quot_ff;
   logic [PROD_W-1:0]    product;
   logic [POS_W-1:0]     quot_in;
   logic [POS_W+QW-1:0]  scaled;
   logic [POS_W-1:0]     saved_ff;

   // helper values for the event logic
   logic [POS_W-1:0]      start_inc;
   logic [POS_W-1:0]      pulse_inc;
   logic [POS_W-1:0]      stall_ext;
   logic                  target_at_end;
   logic                  opv_at_end;
   logic [POS_W-1:0]      target_clamped;
   logic [POS_W-1:0]      opv_clamped;
   logic [POS_W-1:0]      distance;
   logic [POS_W:0]        fwd_sum;
   logic [POS_W-1:0]      fwd_pos;
   logic [POS_W-1:0]      bwd_pos;

   // stall the whole pipe only while a response waits
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign req_accept   = req_ch.valid && advance;
   assign csr_ch.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         full_travel_ff    <= tap_pkg::FULL_TRAVEL_RESET;
         stall_timeout_ff  <= tap_pkg::STALL_TIMEOUT_RESET;
         endpoint_extra_ff <= tap_pkg::ENDPOINT_EXTRA_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            tap_pkg::CSR_FULL_TRAVEL:    full_travel_ff    <= csr_ch.data[POS_W-1:0];
            tap_pkg::CSR_STALL_TIMEOUT:  stall_timeout_ff  <=
                                            csr_ch.data[tap_pkg::STALL_W-1:0];
            tap_pkg::CSR_ENDPOINT_EXTRA: endpoint_extra_ff <= csr_ch.data[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // helper terms
   always_comb begin
      start_inc      = (since_start_ff == tap_pkg::COUNT_MAX) ? since_start_ff
                                                              : since_start_ff + 1'b1;
      pulse_inc      = (since_pulse_ff == tap_pkg::COUNT_MAX) ? since_pulse_ff
                                                              : since_pulse_ff + 1'b1;
      stall_ext      = POS_W'(stall_timeout_ff);
      target_at_end  = (target_ff == '0) || (target_ff == full_travel_ff);
      opv_at_end     = (req_ch.operand_value == '0) ||
                       (req_ch.operand_value == full_travel_ff);
      target_clamped = (target_ff > full_travel_ff) ? full_travel_ff : target_ff;
      opv_clamped    = (req_ch.operand_value > full_travel_ff) ? full_travel_ff
                                                               : req_ch.operand_value;
      distance       = (position_ff > req_ch.operand_value)
                       ? position_ff - req_ch.operand_value
                       : req_ch.operand_value - position_ff;
      fwd_sum        = {1'b0, position_ff} + {1'b0, since_start_ff};
      fwd_pos        = (fwd_sum >= {1'b0, full_travel_ff}) ? full_travel_ff
                                                           : fwd_sum[POS_W-1:0];
      bwd_pos        = (since_start_ff >= position_ff) ? '0
                                                       : position_ff - since_start_ff;
   end

   // next state for one request
   always_comb begin
      motion_in      = motion_ff;
      position_in    = position_ff;
      target_in      = target_ff;
      budget_in      = budget_ff;
      since_start_in = since_start_ff;
      since_pulse_in = since_pulse_ff;
      done_in        = 1'b0;
      save_in        = 1'b0;
      case (req_ch.command)
         tap_pkg::CMD_TICK: begin
            since_start_in = start_inc;
            since_pulse_in = pulse_inc;
            if (motion_ff != tap_pkg::MOT_STOP &&
                (start_inc >= budget_ff || pulse_inc > stall_ext)) begin
               // extend at an endpoint while pulses still arrive
               if (pulse_inc < stall_ext && target_at_end) begin
                  since_start_in = '0;
                  budget_in      = endpoint_extra_ff;
               end else begin
                  position_in = target_clamped;
                  motion_in   = tap_pkg::MOT_STOP;
                  done_in     = 1'b1;
                  save_in     = 1'b1;
               end
            end
         end
         tap_pkg::CMD_PULSE: begin
            since_pulse_in = '0;
         end
         tap_pkg::CMD_MOVE: begin
            target_in = req_ch.operand_value;
            if (req_ch.operand_value != position_ff) begin
               budget_in      = opv_at_end ? full_travel_ff : distance;
               since_start_in = '0;
               since_pulse_in = '0;
               if (position_ff < req_ch.operand_value ||
                   req_ch.operand_value >= full_travel_ff) begin
                  motion_in = tap_pkg::MOT_FWD;
               end else begin
                  motion_in = tap_pkg::MOT_BWD;
               end
            end
         end
         tap_pkg::CMD_STOP: begin
            if (motion_ff != tap_pkg::MOT_STOP) begin
               position_in = (motion_ff == tap_pkg::MOT_FWD) ? fwd_pos : bwd_pos;
               motion_in   = tap_pkg::MOT_STOP;
               save_in     = 1'b1;
            end
         end
         tap_pkg::CMD_RESTORE: begin
            position_in = opv_clamped;
         end
         default: ;
      endcase
   end

   // update state at the request handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff      <= tap_pkg::MOT_STOP;
         position_ff    <= '0;
         target_ff      <= tap_pkg::TARGET_RESET;
         budget_ff      <= '0;
         since_start_ff <= '0;
         since_pulse_ff <= '0;
      end else if (req_accept) begin
         motion_ff      <= motion_in;
         position_ff    <= position_in;
         target_ff      <= target_in;
         budget_ff      <= budget_in;
         since_start_ff <= since_start_in;
         since_pulse_ff <= since_pulse_in;
      end
   end

   // divide by the save quantum through a reciprocal, then scale back
   assign product = PROD_W'(s1_ff.position) * PROD_W'(RECIP_W'(RECIP));
   assign quot_in = product[SHIFT +: POS_W];
   assign scaled  = (POS_W+QW)'(quot_ff) * (POS_W+QW)'(QW'(SAVE_QUANTUM));

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff.motion   <= motion_in;
         s1_ff.position <= position_in;
         s1_ff.done     <= done_in;
         s1_ff.save     <= save_in;
         s2_ff          <= s1_ff;
         quot_ff        <= quot_in;
         s3_ff          <= s2_ff;
         saved_ff       <= s2_ff.save ? scaled[POS_W-1:0] : '0;
      end
   end

   // drive the response
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.drive_forward  = (s3_ff.motion == tap_pkg::MOT_FWD);
   assign rsp_ch.drive_backward = (s3_ff.motion == tap_pkg::MOT_BWD);
   assign rsp_ch.motion         = s3_ff.motion;
   assign rsp_ch.position_now   = s3_ff.position;
   assign rsp_ch.move_done      = s3_ff.done;
   assign rsp_ch.save_strobe    = s3_ff.save;
   assign rsp_ch.saved_position = saved_ff;

endmodule
